@@ design/sacs_pkg.sv @@
package sacs_pkg;

    localparam int MAX_REF_LEN_DEF = 256;
    localparam int ALPHABET_DEF    = 256;
    localparam int SYM_W           = 8;
    localparam int OUT_LEN_W       = 9;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_MATCH  = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [SYM_W-1:0] symbol;
        logic             first;
    } cmd_t;

    typedef struct packed {
        logic [OUT_LEN_W-1:0] match_length;
        logic [OUT_LEN_W-1:0] best_length;
        logic                 truncated;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_EXT,
        S_W1_RD,
        S_W1_CHK,
        S_LQ_CHK,
        S_COPY,
        S_RD_RD,
        S_RD_CHK,
        S_FIN_Q,
        S_FIN_CUR,
        S_M_RD,
        S_M_CHK,
        S_DONE,
        S_RESP
    } state_t;

endpackage

@@ design/sacs_ram.sv @@
module sacs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/suffix_automaton_common_substring.sv @@
// Reference transaction: clears the new node's row, walks the suffix links, and copies
// a row when a node is cloned.
// Query transaction: reads the transition, with suffix-link fallback steps while none exists.
// One transaction at a time: busy is high from acceptance until the done strobe.
// After reset the root row is cleared while busy is high.
// The receiver cannot stall: done marks the result for exactly one cycle.
module suffix_automaton_common_substring #(
    parameter int MAX_REF_LEN = sacs_pkg::MAX_REF_LEN_DEF,
    parameter int ALPHABET    = sacs_pkg::ALPHABET_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  sacs_pkg::cmd_t cmd,
    output logic           done,
    output sacs_pkg::res_t result
);

    import sacs_pkg::*;

    localparam int NODE_CAP = 2 * MAX_REF_LEN;
    localparam int NW       = $clog2(NODE_CAP);
    localparam int CW       = $clog2(NODE_CAP + 1);
    localparam int LW       = $clog2(MAX_REF_LEN + 1);
    localparam int TDEPTH   = NODE_CAP * (2 ** SYM_W);
    localparam int TAW      = NW + SYM_W;

    state_t           state_reg, state_next;
    state_t           ret_reg, ret_next;
    logic [SYM_W-1:0] sym_reg, sym_next;
    logic [SYM_W:0]   cnt_reg, cnt_next;
    logic [NW-1:0]    row_reg, row_next;
    logic [NW-1:0]    cur_reg, cur_next;
    logic [NW-1:0]    cl_reg, cl_next;
    logic [NW-1:0]    p_reg, p_next;
    logic [NW-1:0]    q_reg, q_next;
    logic [LW-1:0]    lenp_reg, lenp_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [NW-1:0]    last_reg, last_next;
    logic [LW-1:0]    last_len_reg, last_len_next;
    logic [NW-1:0]    qnode_reg, qnode_next;
    logic [LW-1:0]    curm_reg, curm_next;
    logic [LW-1:0]    best_reg, best_next;
    logic             cap_reg, cap_next;
    logic             fb_reg, fb_next;

    logic             tr_we, len_we, lk_we;
    logic [TAW-1:0]   tr_waddr, tr_raddr;
    logic [NW-1:0]    tr_wdata, tr_rdata;
    logic [NW-1:0]    len_waddr, len_raddr, lk_waddr, lk_raddr;
    logic [LW-1:0]    len_wdata, len_rdata;
    logic [NW-1:0]    lk_wdata, lk_rdata;
    logic             sym_ok;

    sacs_ram #(.WIDTH(NW), .DEPTH(TDEPTH)) u_trans (
        .clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(tr_wdata),
        .raddr(tr_raddr), .rdata(tr_rdata)
    );

    sacs_ram #(.WIDTH(LW), .DEPTH(NODE_CAP)) u_len (
        .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
        .raddr(len_raddr), .rdata(len_rdata)
    );

    sacs_ram #(.WIDTH(NW), .DEPTH(NODE_CAP)) u_link (
        .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
        .raddr(lk_raddr), .rdata(lk_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            ret_reg      <= S_IDLE;
            cnt_reg      <= '0;
            row_reg      <= '0;
            count_reg    <= CW'(1);
            last_reg     <= '0;
            last_len_reg <= '0;
            qnode_reg    <= '0;
            curm_reg     <= '0;
            best_reg     <= '0;
            cap_reg      <= 1'b0;
            fb_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            cnt_reg      <= cnt_next;
            row_reg      <= row_next;
            count_reg    <= count_next;
            last_reg     <= last_next;
            last_len_reg <= last_len_next;
            qnode_reg    <= qnode_next;
            curm_reg     <= curm_next;
            best_reg     <= best_next;
            cap_reg      <= cap_next;
            fb_reg       <= fb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg  <= sym_next;
        cur_reg  <= cur_next;
        cl_reg   <= cl_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        lenp_reg <= lenp_next;
    end

    assign sym_ok = ({1'b0, cmd.symbol} < (SYM_W + 1)'(ALPHABET));

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        sym_next      = sym_reg;
        cnt_next      = cnt_reg;
        row_next      = row_reg;
        cur_next      = cur_reg;
        cl_next       = cl_reg;
        p_next        = p_reg;
        q_next        = q_reg;
        lenp_next     = lenp_reg;
        count_next    = count_reg;
        last_next     = last_reg;
        last_len_next = last_len_reg;
        qnode_next    = qnode_reg;
        curm_next     = curm_reg;
        best_next     = best_reg;
        cap_next      = cap_reg;
        fb_next       = fb_reg;

        tr_we     = 1'b0;
        tr_waddr  = {p_reg, sym_reg};
        tr_wdata  = '0;
        tr_raddr  = {p_reg, sym_reg};
        len_we    = 1'b0;
        len_waddr = cur_reg;
        len_wdata = '0;
        len_raddr = p_reg;
        lk_we     = 1'b0;
        lk_waddr  = cur_reg;
        lk_wdata  = '0;
        lk_raddr  = p_reg;
        done      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    sym_next = cmd.symbol;
                    if (cmd.operation == OP_APPEND)
                    begin
                        state_next = sym_ok ? S_EXT : S_DONE;
                        if (cmd.first)
                        begin
                            count_next    = CW'(1);
                            last_next     = '0;
                            last_len_next = '0;
                            cap_next      = 1'b0;
                            qnode_next    = '0;
                            curm_next     = '0;
                            best_next     = '0;
                            row_next      = '0;
                            cnt_next      = '0;
                            ret_next      = sym_ok ? S_EXT : S_DONE;
                            state_next    = S_CLEAR;
                        end
                    end
                    else
                    begin
                        fb_next = 1'b0;
                        p_next  = cmd.first ? '0 : qnode_reg;
                        if (cmd.first)
                        begin
                            qnode_next = '0;
                            curm_next  = '0;
                            best_next  = '0;
                        end
                        if (sym_ok)
                        begin
                            state_next = S_M_RD;
                        end
                        else
                        begin
                            qnode_next = '0;
                            curm_next  = '0;
                            state_next = S_DONE;
                        end
                    end
                end
            end

            S_CLEAR:
            begin
                tr_we    = 1'b1;
                tr_waddr = {row_reg, cnt_reg[SYM_W-1:0]};
                if (row_reg == '0)
                begin
                    len_we    = 1'b1;
                    len_waddr = '0;
                    lk_we     = 1'b1;
                    lk_waddr  = '0;
                end
                if (cnt_reg == (SYM_W + 1)'(ALPHABET - 1))
                begin
                    cnt_next   = '0;
                    state_next = ret_reg;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_EXT:
            begin
                if ((last_len_reg >= LW'(MAX_REF_LEN)) ||
                    ({1'b0, count_reg} + 2'd2 > (CW + 1)'(NODE_CAP)))
                begin
                    cap_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next      = count_reg[NW-1:0];
                    len_we        = 1'b1;
                    len_waddr     = count_reg[NW-1:0];
                    len_wdata     = last_len_reg + 1'b1;
                    lk_we         = 1'b1;
                    lk_waddr      = count_reg[NW-1:0];
                    count_next    = count_reg + 1'b1;
                    p_next        = last_reg;
                    last_next     = count_reg[NW-1:0];
                    last_len_next = last_len_reg + 1'b1;
                    row_next      = count_reg[NW-1:0];
                    cnt_next      = '0;
                    ret_next      = S_W1_RD;
                    state_next    = S_CLEAR;
                end
            end

            S_W1_RD:
            begin
                state_next = S_W1_CHK;
            end

            S_W1_CHK:
            begin
                if (tr_rdata != '0)
                begin
                    q_next     = tr_rdata;
                    lenp_next  = len_rdata;
                    len_raddr  = tr_rdata;
                    lk_raddr   = tr_rdata;
                    state_next = S_LQ_CHK;
                end
                else
                begin
                    tr_we    = 1'b1;
                    tr_wdata = cur_reg;
                    if (p_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        p_next     = lk_rdata;
                        state_next = S_W1_RD;
                    end
                end
            end

            S_LQ_CHK:
            begin
                if (lenp_reg + 1'b1 == len_rdata)
                begin
                    lk_we      = 1'b1;
                    lk_wdata   = q_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    cl_next    = count_reg[NW-1:0];
                    len_we     = 1'b1;
                    len_waddr  = count_reg[NW-1:0];
                    len_wdata  = lenp_reg + 1'b1;
                    lk_we      = 1'b1;
                    lk_waddr   = count_reg[NW-1:0];
                    lk_wdata   = lk_rdata;
                    count_next = count_reg + 1'b1;
                    cnt_next   = '0;
                    state_next = S_COPY;
                end
            end

            S_COPY:
            begin
                tr_raddr = {q_reg, cnt_reg[SYM_W-1:0]};
                tr_waddr = {cl_reg, SYM_W'(cnt_reg - 1'b1)};
                tr_wdata = tr_rdata;
                tr_we    = (cnt_reg != '0);
                if (cnt_reg == (SYM_W + 1)'(ALPHABET))
                begin
                    cnt_next   = '0;
                    state_next = S_RD_RD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_RD_RD:
            begin
                state_next = S_RD_CHK;
            end

            S_RD_CHK:
            begin
                if (tr_rdata != q_reg)
                begin
                    state_next = S_FIN_Q;
                end
                else
                begin
                    tr_we    = 1'b1;
                    tr_wdata = cl_reg;
                    if (p_reg == '0)
                    begin
                        state_next = S_FIN_Q;
                    end
                    else
                    begin
                        p_next     = lk_rdata;
                        state_next = S_RD_RD;
                    end
                end
            end

            S_FIN_Q:
            begin
                lk_we      = 1'b1;
                lk_waddr   = q_reg;
                lk_wdata   = cl_reg;
                state_next = S_FIN_CUR;
            end

            S_FIN_CUR:
            begin
                lk_we      = 1'b1;
                lk_wdata   = cl_reg;
                state_next = S_DONE;
            end

            S_M_RD:
            begin
                state_next = S_M_CHK;
            end

            S_M_CHK:
            begin
                if (tr_rdata != '0)
                begin
                    curm_next  = fb_reg ? (len_rdata + 1'b1) : (curm_reg + 1'b1);
                    qnode_next = tr_rdata;
                    state_next = S_DONE;
                end
                else if (p_reg == '0)
                begin
                    qnode_next = '0;
                    curm_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    p_next     = lk_rdata;
                    fb_next    = 1'b1;
                    state_next = S_M_RD;
                end
            end

            S_DONE:
            begin
                if (curm_reg > best_reg)
                begin
                    best_next = curm_reg;
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy                = (state_reg != S_IDLE);
    assign result.match_length = OUT_LEN_W'(curm_reg);
    assign result.best_length  = OUT_LEN_W'(best_reg);
    assign result.truncated    = cap_reg;

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done strobe outside a transaction");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (curm_reg <= best_reg))
        else $error("match length above best length");

    a_node_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(NODE_CAP))
        else $error("node count past capacity");

endmodule

@@ verif/suffix_automaton_common_substring_tb.sv @@
`timescale 1ns / 1ps

module suffix_automaton_common_substring_tb;

    import sacs_pkg::*;

    localparam int REF_LIMIT = 256;
    localparam int NODE_LIMIT = 2 * REF_LIMIT;
    localparam int WATCHDOG_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t cmd;
    logic done;
    res_t result;

    suffix_automaton_common_substring i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    int unsigned sa_len [NODE_LIMIT];
    int unsigned sa_link [NODE_LIMIT];
    int unsigned sa_next [NODE_LIMIT][256];
    int unsigned sa_count;
    int unsigned sa_last;
    int unsigned qry_node;
    int unsigned qry_len;
    int unsigned qry_best;
    bit ref_full;

    cmd_t pending_cmds[$];
    res_t expected_results[$];
    int unsigned error_count = 0;
    int unsigned stall_cycles = 0;
    bit hold_sender;

    function automatic void clear_row(input int unsigned n);
        for (int s = 0; s < 256; s++)
        begin
            sa_next[n][s] = '0;
        end
    endfunction

    function automatic void append_symbol(input int unsigned c);
        int unsigned cur;
        int unsigned p;
        int unsigned q;
        int unsigned cl;
        bit found;
        found = 1'b0;
        if (sa_len[sa_last] >= REF_LIMIT || sa_count + 2 > NODE_LIMIT)
        begin
            ref_full = 1'b1;
            return;
        end
        cur = sa_count;
        sa_count++;
        sa_len[cur] = sa_len[sa_last] + 1;
        sa_link[cur] = '0;
        clear_row(cur);
        p = sa_last;
        sa_last = cur;
        forever
        begin
            if (sa_next[p][c] != 0)
            begin
                found = 1'b1;
                break;
            end
            sa_next[p][c] = cur;
            if (p == 0)
                break;
            p = sa_link[p];
        end
        if (!found)
            return;
        q = sa_next[p][c];
        if (sa_len[p] + 1 == sa_len[q])
        begin
            sa_link[cur] = q;
            return;
        end
        cl = sa_count;
        sa_count++;
        sa_len[cl] = sa_len[p] + 1;
        for (int s = 0; s < 256; s++)
        begin
            sa_next[cl][s] = sa_next[q][s];
        end
        sa_link[cl] = sa_link[q];
        forever
        begin
            if (sa_next[p][c] != q)
                break;
            sa_next[p][c] = cl;
            if (p == 0)
                break;
            p = sa_link[p];
        end
        sa_link[q] = cl;
        sa_link[cur] = cl;
    endfunction

    function automatic void match_symbol(input int unsigned c);
        int unsigned n;
        n = qry_node;
        if (sa_next[n][c] != 0)
        begin
            qry_len++;
            qry_node = sa_next[n][c];
        end
        else
        begin
            while (n != 0 && sa_next[n][c] == 0)
                n = sa_link[n];
            if (sa_next[n][c] == 0)
            begin
                qry_node = 0;
                qry_len = 0;
            end
            else
            begin
                qry_len = sa_len[n] + 1;
                qry_node = sa_next[n][c];
            end
        end
        if (qry_len > qry_best)
            qry_best = qry_len;
    endfunction

    function automatic void restart_query();
        qry_node = 0;
        qry_len = 0;
        qry_best = 0;
    endfunction

    function automatic void clear_automaton();
        clear_row(0);
        sa_len[0] = '0;
        sa_link[0] = '0;
        sa_count = 1;
        sa_last = 0;
        ref_full = 1'b0;
    endfunction

    function automatic res_t predict_substring(input cmd_t c);
        res_t r;
        if (c.operation == OP_APPEND)
        begin
            if (c.first)
            begin
                clear_automaton();
                restart_query();
            end
            append_symbol(32'(c.symbol));
        end
        else
        begin
            if (c.first)
                restart_query();
            match_symbol(32'(c.symbol));
        end
        r.match_length = qry_len[8:0];
        r.best_length = qry_best[8:0];
        r.truncated = ref_full;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic cmd_t make_cmd(input logic op, input int unsigned s, input logic f);
        cmd_t c;
        c.operation = op;
        c.symbol = s[7:0];
        c.first = f;
        return c;
    endfunction

    function automatic void enqueue_cmd(input cmd_t c);
        pending_cmds = {pending_cmds, c};
    endfunction

    // transaction driver
    int unsigned gap_left;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= '0;
            gap_left <= 0;
        end
        else if (start && busy)
        begin
        end
        else if (gap_left != 0)
        begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (!busy && pending_cmds.size() != 0
                 && !(hold_sender && expected_results.size() != 0))
        begin
            start <= 1'b1;
            cmd <= pending_cmds.pop_front();
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // accept and predict at the rising edge; compare completions
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            if ((start && !busy) || done)
            begin
                stall_cycles <= 0;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
            if (start && !busy)
            begin
                expected_results = {expected_results, predict_substring(cmd)};
            end
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("unexpected transaction result at %0t", $realtime);
                    error_count++;
                end
                else
                begin
                    res_t w;
                    w = expected_results.pop_front();
                    if (result.match_length != w.match_length)
                        report_mismatch("match_length", 32'(result.match_length),
                                        32'(w.match_length));
                    if (result.best_length != w.best_length)
                        report_mismatch("best_length", 32'(result.best_length),
                                        32'(w.best_length));
                    if (result.truncated != w.truncated)
                        report_mismatch("truncated", 32'(result.truncated),
                                        32'(w.truncated));
                end
            end
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("suffix_automaton_common_substring verification failed");
                $finish;
            end
        end
    end

    task automatic add_reference(input int unsigned len, input int unsigned alpha,
                                 input bit fresh);
        for (int i = 0; i < len; i++)
        begin
            enqueue_cmd(make_cmd(OP_APPEND, $urandom_range(0, alpha - 1),
                                 fresh && i == 0));
        end
    endtask

    task automatic add_query(input int unsigned len, input int unsigned alpha);
        for (int i = 0; i < len; i++)
        begin
            enqueue_cmd(make_cmd(OP_MATCH, $urandom_range(0, alpha - 1), i == 0));
        end
    endtask

    initial
    begin
        int unsigned alpha;
        rst_n = 1'b0;
        hold_sender = 1'b0;
        for (int n = 0; n < NODE_LIMIT; n++)
        begin
            sa_len[n] = '0;
            sa_link[n] = '0;
            clear_row(n);
        end
        clear_automaton();
        restart_query();

        // directed: query on empty automaton, extremes, fallback
        enqueue_cmd(make_cmd(OP_MATCH, 'h00, 1'b0));
        enqueue_cmd(make_cmd(OP_APPEND, 'h00, 1'b1));
        enqueue_cmd(make_cmd(OP_APPEND, 'hFF, 1'b0));
        enqueue_cmd(make_cmd(OP_APPEND, 'h00, 1'b0));
        enqueue_cmd(make_cmd(OP_APPEND, 'h00, 1'b0));
        enqueue_cmd(make_cmd(OP_APPEND, 'hFF, 1'b0));
        enqueue_cmd(make_cmd(OP_MATCH, 'hFF, 1'b1));
        enqueue_cmd(make_cmd(OP_MATCH, 'h00, 1'b0));
        enqueue_cmd(make_cmd(OP_MATCH, 'h00, 1'b0));
        enqueue_cmd(make_cmd(OP_MATCH, 'hFF, 1'b0));
        enqueue_cmd(make_cmd(OP_MATCH, 'hFF, 1'b0));
        enqueue_cmd(make_cmd(OP_MATCH, 'h55, 1'b0));
        enqueue_cmd(make_cmd(OP_APPEND, 'h55, 1'b0));
        enqueue_cmd(make_cmd(OP_MATCH, 'h55, 1'b0));
        enqueue_cmd(make_cmd(OP_MATCH, 'hAA, 1'b1));
        enqueue_cmd(make_cmd(OP_APPEND, 'hAA, 1'b1));
        enqueue_cmd(make_cmd(OP_MATCH, 'hAA, 1'b0));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_cmds.size() == 0);
        hold_sender = 1'b1;
        add_query(3, 4);
        wait (pending_cmds.size() == 0 && expected_results.size() == 0);
        hold_sender = 1'b0;

        // capacity: overfill with a binary reference, then query it
        add_reference(270, 2, 1'b1);
        add_query(12, 2);

        for (int k = 0; k < 10; k++)
        begin
            alpha = $urandom_range(0, 2) == 0 ? 256 : $urandom_range(2, 4);
            add_reference($urandom_range(1, 10), alpha, 1'b1);
            add_query($urandom_range(2, 8), alpha);
            if ($urandom_range(0, 1))
                add_reference($urandom_range(1, 3), alpha, 1'b0);
            add_query($urandom_range(1, 4), alpha);
            if ($urandom_range(0, 4) == 0)
                enqueue_cmd(make_cmd(1'($urandom_range(0, 1)), $urandom_range(0, 255),
                                     1'($urandom_range(0, 1))));
        end

        wait (pending_cmds.size() == 0 && expected_results.size() == 0);
        repeat (1200) @(posedge clk);
        if (error_count == 0)
            $display("suffix_automaton_common_substring verification clean");
        else
            $display("suffix_automaton_common_substring verification failed");
        $finish;
    end

endmodule
